// ----- rtl/irdq_pkg.sv -----
// Package: request codes and transaction payload types of the in-order release decrypt queue.
`default_nettype none

package irdq_pkg;

  // Request codes
  localparam logic [2:0] REQ_PUSH = 3'd0;
  localparam logic [2:0] REQ_FIND = 3'd1;
  localparam logic [2:0] REQ_PEEK = 3'd2;
  localparam logic [2:0] REQ_POP  = 3'd3;
  localparam logic [2:0] REQ_MARK = 3'd4;

  // Entry payload kept in RAM: pdu reference, direction, timestamp
  localparam int unsigned REF_W  = 16;
  localparam int unsigned DIR_W  = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ENTRY_W = REF_W + DIR_W + TIME_W;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [REF_W-1:0]  pdu_ref;
    logic              need_decrypt;
    logic [DIR_W-1:0]  direction;
    logic [TIME_W-1:0] timestamp;
    logic [3:0]        slot_sel;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [3:0]        slot;
    logic [REF_W-1:0]  out_pdu_ref;
    logic              out_need_decrypt;
    logic [DIR_W-1:0]  out_direction;
    logic [TIME_W-1:0] out_timestamp;
    logic [4:0]        fill;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/irdq_req_if.sv -----
// Interface: request channel with valid/ready handshake.
`default_nettype none

interface irdq_req_if
  import irdq_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/irdq_rsp_if.sv -----
// Interface: response channel with valid/ready handshake.
`default_nettype none

interface irdq_rsp_if
  import irdq_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/irdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module irdq_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/inorder_release_decrypt_queue_top.sv -----
// Top level: in-order release ring queue of packets awaiting decryption.
// Response path: decode at accept, RAM read in the read state, then the output register.
// Requests are accepted only in idle, after the previous one has left its read cycle.
// A waiting response holds the next request in its read cycle and stalls request accept.
// Reset (async, active low) empties the queue: pointers, count and held bits clear.
// Entry payload and pending flags are not reset; only held entries are ever read.
`default_nettype none

module inorder_release_decrypt_queue_top
  import irdq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  irdq_req_if.sink    req_i,
  irdq_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_q, state_d;

  logic [IDX_W-1:0] wptr_q, wptr_d;
  logic [IDX_W-1:0] rptr_q, rptr_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [QUEUE_DEPTH-1:0] held_q, held_d;
  logic [QUEUE_DEPTH-1:0] pend_q, pend_d;

  // Per-request capture for the read cycle
  logic             ok_q, ok_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             flag_q, flag_d;
  logic             push_q;
  logic [ENTRY_W-1:0] push_data_q;
  logic [OCC_W-1:0] fill_q;

  logic       rsp_valid_q;
  rsp_t       rsp_q, rsp_d;

  logic               accept;
  logic               rsp_load;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] in_entry;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
    wrap_next = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign in_entry    = {req_i.data.pdu_ref, req_i.data.direction, req_i.data.timestamp};

  // Find: oldest pending held entry, searched from the head around the ring
  logic [QUEUE_DEPTH-1:0] cand, cand_up;
  logic [IDX_W-1:0]       idx_up, idx_any;
  always_comb begin
    cand    = pend_q & held_q;
    idx_up  = '0;
    idx_any = '0;
    for (int j = QUEUE_DEPTH - 1; j >= 0; j--) begin
      cand_up[j] = cand[j] && (IDX_W'(j) >= rptr_q);
    end
    for (int j = QUEUE_DEPTH - 1; j >= 0; j--) begin
      if (cand_up[j]) idx_up = IDX_W'(j);
      if (cand[j]) idx_any = IDX_W'(j);
    end
  end

  // Mark slot decode
  logic             sel_in_range;
  logic [IDX_W-1:0] sel_idx;
  assign sel_in_range = (32'(req_i.data.slot_sel) < QUEUE_DEPTH);
  assign sel_idx      = IDX_W'(req_i.data.slot_sel);

  // Request decode and state update at accept
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    occ_d  = occ_q;
    held_d = held_q;
    pend_d = pend_q;
    ok_d   = 1'b0;
    slot_d = '0;
    flag_d = 1'b0;
    case (req_i.data.req_type)
      REQ_PUSH: begin
        if (occ_q != FULL_OCC) begin
          ok_d           = 1'b1;
          slot_d         = wptr_q;
          flag_d         = req_i.data.need_decrypt;
          held_d[wptr_q] = 1'b1;
          pend_d[wptr_q] = req_i.data.need_decrypt;
          wptr_d         = wrap_next(wptr_q);
          occ_d          = occ_q + 1'b1;
        end
      end
      REQ_FIND: begin
        ok_d   = |cand;
        slot_d = (|cand_up) ? idx_up : idx_any;
        flag_d = 1'b1;
      end
      REQ_PEEK, REQ_POP: begin
        if (held_q[rptr_q] && !pend_q[rptr_q]) begin
          ok_d   = 1'b1;
          slot_d = rptr_q;
          if (req_i.data.req_type == REQ_POP) begin
            held_d[rptr_q] = 1'b0;
            rptr_d         = wrap_next(rptr_q);
            occ_d          = occ_q - 1'b1;
          end
        end
      end
      REQ_MARK: begin
        if (sel_in_range && held_q[sel_idx]) begin
          ok_d            = 1'b1;
          slot_d          = sel_idx;
          pend_d[sel_idx] = 1'b0;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Entry payload RAM
  irdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (accept && ok_d && (req_i.data.req_type == REQ_PUSH)),
    .waddr_i (wptr_q),
    .wdata_i (in_entry),
    .re_i    (accept && ok_d && (req_i.data.req_type != REQ_PUSH)),
    .raddr_i (slot_d),
    .rdata_o (ram_rdata)
  );

  // Sequencer: result leaves the read cycle once the output register is free
  assign rsp_load = (state_q == ST_READ) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: if (rsp_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Response assembly
  logic [ENTRY_W-1:0] res_entry;
  always_comb begin
    res_entry = push_q ? push_data_q : ram_rdata;
    rsp_d     = '0;
    rsp_d.fill = 5'(fill_q);
    if (ok_q) begin
      rsp_d.ok               = 1'b1;
      rsp_d.slot             = 4'(slot_q);
      rsp_d.out_need_decrypt = flag_q;
      {rsp_d.out_pdu_ref, rsp_d.out_direction, rsp_d.out_timestamp} = res_entry;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      occ_q       <= '0;
      held_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        wptr_q <= wptr_d;
        rptr_q <= rptr_d;
        occ_q  <= occ_d;
        held_q <= held_d;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q      <= pend_d;
      ok_q        <= ok_d;
      slot_q      <= slot_d;
      flag_q      <= flag_d;
      push_q      <= (req_i.data.req_type == REQ_PUSH);
      push_data_q <= in_entry;
      fill_q      <= occ_d;
    end
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule

`default_nettype wire
